// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/tes_pkg.sv =====
package tes_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIDX_W    = 4;
  localparam int PIN_W     = 5;
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 64;
  localparam int NDELAY    = 4;

  localparam int S_TDATA_W = 176;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 160;
  localparam int M_TUSER_W = 3;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADD     = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REWRITE = 3'd4,
    OP_ENABLE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_BUSY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [NDELAY-1:0][WORD_W-1:0] delay;
    logic [WORD_W-1:0]             mask;
    logic [PIN_W-1:0]              pin;
  } task_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic tick_step;
    logic tick_launch;
    logic rd_ptr;
    logic shift_write;
    logic shift_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic start_shift;
    logic shift_more;
    logic relaunch;
  } sts_t;

endpackage

// ===== rtl/tes_datapath.sv =====
`include "assert_macros.svh"

module tes_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tes_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [tes_pkg::S_TUSER_W-1:0] s_tuser,
  input  tes_pkg::cmd_t                 cmd,
  output tes_pkg::sts_t                 sts,
  output logic [tes_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [tes_pkg::M_TUSER_W-1:0] m_tuser
);
  import tes_pkg::*;

  localparam logic [2:0] PH_LASER_ON_NEXT  = 3'd0;
  localparam logic [2:0] PH_WAIT_CAMERA    = 3'd1;
  localparam logic [2:0] PH_CAMERA_HIGH    = 3'd2;
  localparam logic [2:0] PH_WAIT_LASER_OFF = 3'd3;
  localparam logic [2:0] PH_LASER_OFF      = 3'd4;

  function automatic logic [WORD_W-1:0] ticks_less_one(input logic [WORD_W-1:0] d);
    return (d == '0) ? '0 : d - WORD_W'(1);
  endfunction

  // input beat
  op_t               in_op;
  logic [TIDX_W-1:0] in_idx;
  task_t             in_entry;
  logic              in_en;

  // sequencer state
  logic [CNT_W-1:0]  count;
  logic              running;
  logic              pending;
  logic [IDX_W-1:0]  cur;
  logic [2:0]        phase;
  logic [WORD_W-1:0] rem;
  logic [TIME_W-1:0] now_us;
  logic [CNT_W-1:0]  ptr;
  status_t           status;
  logic              ev_valid;
  logic [WORD_W-1:0] ev_state;
  logic [TIME_W-1:0] ev_time;

  // task table
  task_t             mem [MAX_TASKS];
  task_t             rdata;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  task_t             wdata;
  logic [IDX_W-1:0]  raddr;

  // output payload
  logic [WORD_W-1:0] out_laser;
  logic [WORD_W-1:0] out_cam;
  logic [WORD_W-1:0] out_ev_state;
  logic [TIME_W-1:0] out_ev_time;
  logic              out_ev_valid;
  status_t           out_status;

  logic              table_op;
  logic              refuse;
  logic              idx_ok;
  logic              full;
  logic [CNT_W-1:0]  ptr_inc;
  logic [CNT_W-1:0]  cur_inc;
  logic              last_task;
  logic [WORD_W-1:0] pin_hot;
  logic              show;

  assign table_op  = (in_op == OP_ADD) || (in_op == OP_REMOVE) ||
                     (in_op == OP_CLEAR) || (in_op == OP_REWRITE);
  assign refuse    = running && table_op;
  assign idx_ok    = CNT_W'(in_idx) < count;
  assign full      = count >= CNT_W'(MAX_TASKS);
  assign ptr_inc   = ptr + CNT_W'(1);
  assign cur_inc   = CNT_W'(cur) + CNT_W'(1);
  assign last_task = cur_inc >= count;
  assign pin_hot   = WORD_W'(1) << rdata.pin;
  assign show      = running && (count != '0) &&
                     (phase >= PH_WAIT_CAMERA) && (phase <= PH_WAIT_LASER_OFF);

  assign sts.is_tick     = (in_op == OP_TICK);
  assign sts.start_shift = (in_op == OP_REMOVE) && !refuse && idx_ok;
  assign sts.shift_more  = ptr_inc < count;
  assign sts.relaunch    = running && (count != '0) && (phase == PH_LASER_OFF) &&
                           (rem == '0) && (!last_task || pending);

  assign raddr = cmd.rd_ptr ? ptr_inc[IDX_W-1:0] : cur;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = in_entry;
    if (cmd.exec && !refuse) begin
      if (in_op == OP_ADD && !full) begin
        we    = 1'b1;
        waddr = count[IDX_W-1:0];
      end else if (in_op == OP_REWRITE && idx_ok) begin
        we    = 1'b1;
        waddr = in_idx[IDX_W-1:0];
      end
    end else if (cmd.shift_write) begin
      we    = 1'b1;
      waddr = ptr[IDX_W-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_op                <= op_t'(s_tuser);
      in_idx               <= s_tdata[3:0];
      in_entry.pin         <= s_tdata[8:4];
      in_entry.mask        <= s_tdata[40:9];
      in_entry.delay[0]    <= s_tdata[72:41];
      in_entry.delay[1]    <= s_tdata[104:73];
      in_entry.delay[2]    <= s_tdata[136:105];
      in_entry.delay[3]    <= s_tdata[168:137];
      in_en                <= s_tdata[169];
      ev_time              <= now_us;
    end
    if (cmd.load_out) begin
      out_status   <= status;
      out_laser    <= show ? pin_hot : '0;
      out_cam      <= (show && phase == PH_CAMERA_HIGH) ? rdata.mask : '0;
      out_ev_valid <= ev_valid;
      out_ev_state <= ev_state;
      out_ev_time  <= ev_valid ? ev_time : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      running  <= 1'b0;
      pending  <= 1'b0;
      cur      <= '0;
      phase    <= PH_LASER_ON_NEXT;
      rem      <= '0;
      now_us   <= '0;
      ptr      <= '0;
      status   <= STAT_OK;
      ev_valid <= 1'b0;
      ev_state <= '0;
    end else begin
      if (cmd.capture) begin
        status   <= STAT_OK;
        ev_valid <= 1'b0;
        ev_state <= '0;
        if (op_t'(s_tuser) == OP_TICK) begin
          now_us <= now_us + TIME_W'(1);
        end
      end

      if (cmd.exec) begin
        if (refuse) begin
          status <= STAT_BUSY;
        end else begin
          case (in_op)
            OP_ADD: begin
              if (full) begin
                status <= STAT_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (!idx_ok) begin
                status <= STAT_RANGE;
              end else begin
                ptr <= CNT_W'(in_idx);
              end
            end
            OP_CLEAR: begin
              count <= '0;
            end
            OP_REWRITE: begin
              if (!idx_ok) begin
                status <= STAT_RANGE;
              end
            end
            OP_ENABLE: begin
              pending <= in_en;
              if (!running) begin
                running <= in_en;
                cur     <= '0;
                phase   <= PH_LASER_ON_NEXT;
                rem     <= '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      if (cmd.shift_write) begin
        ptr <= ptr_inc;
      end
      if (cmd.shift_done) begin
        count <= count - CNT_W'(1);
      end

      if (cmd.tick_launch) begin
        ev_valid <= 1'b1;
        ev_state <= pin_hot;
        phase    <= PH_WAIT_CAMERA;
        rem      <= ticks_less_one(rdata.delay[0]);
      end else if (cmd.tick_step && running) begin
        if (count == '0) begin
          running <= pending;
          cur     <= '0;
          phase   <= PH_LASER_ON_NEXT;
        end else if (phase != PH_LASER_ON_NEXT && rem != '0) begin
          rem <= rem - WORD_W'(1);
        end else begin
          case (phase)
            PH_WAIT_CAMERA: begin
              ev_valid <= 1'b1;
              ev_state <= pin_hot | rdata.mask;
              phase    <= PH_CAMERA_HIGH;
              rem      <= ticks_less_one(rdata.delay[1]);
            end
            PH_CAMERA_HIGH: begin
              phase <= PH_WAIT_LASER_OFF;
              rem   <= ticks_less_one(rdata.delay[2]);
            end
            PH_WAIT_LASER_OFF: begin
              phase <= PH_LASER_OFF;
              rem   <= ticks_less_one(rdata.delay[3]);
            end
            PH_LASER_OFF: begin
              phase <= PH_LASER_ON_NEXT;
              rem   <= '0;
              if (last_task) begin
                cur     <= '0;
                running <= pending;
              end else begin
                cur <= cur_inc[IDX_W-1:0];
              end
            end
            default: begin
              ev_valid <= 1'b1;
              ev_state <= pin_hot;
              phase    <= PH_WAIT_CAMERA;
              rem      <= ticks_less_one(rdata.delay[0]);
            end
          endcase
        end
      end
    end
  end

  // m_tdata: laser_pins, camera_pins, event_state, event_time
  assign m_tdata = {out_ev_time, out_ev_state, out_cam, out_laser};
  // m_tuser: status, event_valid
  assign m_tuser = {out_ev_valid, out_status};

  `ASSERT_ALWAYS(a_count_max, clk, rst, count <= CNT_W'(MAX_TASKS), "task count over limit")
  `ASSERT_IMPLY(a_cur_in_table, clk, rst, running && count != '0, CNT_W'(cur) < count, "current task past table end")
  `ASSERT_IMPLY(a_event_pins, clk, rst, ev_valid, ev_state != '0, "event with no pins")
  `ASSERT_NEXT(a_table_frozen, clk, rst, running, count == $past(count), "table changed while running")

endmodule

// ===== rtl/tes_ctrl.sv =====
module tes_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  tes_pkg::sts_t sts,
  output tes_pkg::cmd_t cmd
);
  import tes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TRD,
    S_TEXEC,
    S_SRD,
    S_SWR,
    S_ORD,
    S_OUT
  } state_t;

  state_t state, state_next;
  logic   launch, launch_next;
  logic   m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    launch_next   = launch;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_tick) begin
          launch_next = 1'b0;
          state_next  = S_TRD;
        end else if (sts.start_shift) begin
          state_next = S_SRD;
        end else begin
          state_next = S_ORD;
        end
      end
      S_TRD: begin
        state_next = S_TEXEC;
      end
      S_TEXEC: begin
        if (launch) begin
          cmd.tick_launch = 1'b1;
          launch_next     = 1'b0;
          state_next      = S_ORD;
        end else begin
          cmd.tick_step = 1'b1;
          if (sts.relaunch) begin
            launch_next = 1'b1;
            state_next  = S_TRD;
          end else begin
            state_next = S_ORD;
          end
        end
      end
      S_SRD: begin
        if (sts.shift_more) begin
          cmd.rd_ptr = 1'b1;
          state_next = S_SWR;
        end else begin
          cmd.shift_done = 1'b1;
          state_next     = S_ORD;
        end
      end
      S_SWR: begin
        cmd.shift_write = 1'b1;
        state_next      = S_SRD;
      end
      S_ORD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      launch   <= launch_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== rtl/timed_exposure_sequencer.sv =====
// Exposure task sequencer. Each input beat carries one operation in s_tuser
// (tick, add, remove, clear, rewrite, set enable) and yields exactly one result
// beat with the status, the laser and camera pins now driven and any rising-edge
// event with its microsecond time. Beats are handled one at a time: a tick reads
// the current task and steps it, and reads again when a task ends and the next
// one starts; a remove that compacts moves each table entry above the removed
// slot down by one, one entry per read/write pair, since the task memory has one
// read port and one write port. A finished result
// sits in the output register, so the next beat is taken while it waits.
module timed_exposure_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // slot, laser_pin, camera_mask, delay_after_laser, delay_outputs_on,
  // delay_before_laser_off, delay_after_laser_off, enable_value, zero pad
  input  logic [tes_pkg::S_TDATA_W-1:0] s_tdata,
  // op
  input  logic [tes_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // laser_pins, camera_pins, event_state, event_time
  output logic [tes_pkg::M_TDATA_W-1:0] m_tdata,
  // status, event_valid
  output logic [tes_pkg::M_TUSER_W-1:0] m_tuser
);
  import tes_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tes_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ===== sim/timed_exposure_sequencer_tb.sv =====
`timescale 1ns / 100ps

module timed_exposure_sequencer_tb;
  import tes_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int BEAT_TARGET = 1550;
  localparam int CALM_AFTER  = 1350;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 64;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef enum logic [2:0] {
    SEQ_ARM, SEQ_PRE_CAM, SEQ_CAM, SEQ_POST_CAM, SEQ_DARK
  } seq_phase_t;

  typedef struct packed {
    logic [2:0]             op;
    logic [3:0]             idx;
    logic [4:0]             pin;
    logic [31:0]            mask;
    logic [3:0][31:0]       dly;
    logic                   en;
  } beat_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lasers;
    logic [31:0] cams;
    logic        ev;
    logic [31:0] ev_state;
    logic [63:0] ev_time;
  } pin_state_t;

  typedef struct {
    beat_in_t beat;
    int       reps;
    bit       typed;
    status_t  want_st;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  timed_exposure_sequencer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the sequencer
  logic [4:0]       pin_tab  [MAX_TASKS];
  logic [31:0]      mask_tab [MAX_TASKS];
  logic [3:0][31:0] dly_tab  [MAX_TASKS];
  int unsigned      n_tasks = 0;
  bit               run_on = 0;
  bit               run_next = 0;
  int unsigned      cur = 0;
  seq_phase_t       ph = SEQ_ARM;
  logic [31:0]      left_us = '0;
  logic [63:0]      now_us = '0;
  bit               ev_flag;
  logic [31:0]      ev_pins;

  pin_state_t results_due[$];
  dir_row_t   dir_rows[$];
  int         errors = 0;
  int         beats_sent = 0;
  int         results_seen = 0;
  int         events_seen = 0;
  int         rounds_started = 0;
  int         cycle_cnt = 0;
  bit         calm = 0;
  logic [3:0] hold_req = '0;

  function automatic logic [31:0] less_one(logic [31:0] d);
    return (d == 0) ? 32'd0 : d - 32'd1;
  endfunction

  function void start_task();
    ev_flag = 1'b1;
    ev_pins = 32'd1 << pin_tab[cur];
    ph      = SEQ_PRE_CAM;
    left_us = less_one(dly_tab[cur][0]);
  endfunction

  function void step_tick();
    if (!run_on) return;
    if (n_tasks == 0) begin
      run_on = run_next;
      cur    = 0;
      ph     = SEQ_ARM;
      return;
    end
    if (ph != SEQ_ARM && left_us != 0) begin
      left_us = left_us - 32'd1;
      return;
    end
    case (ph)
      SEQ_PRE_CAM: begin
        ev_flag = 1'b1;
        ev_pins = (32'd1 << pin_tab[cur]) | mask_tab[cur];
        ph      = SEQ_CAM;
        left_us = less_one(dly_tab[cur][1]);
      end
      SEQ_CAM: begin
        ph      = SEQ_POST_CAM;
        left_us = less_one(dly_tab[cur][2]);
      end
      SEQ_POST_CAM: begin
        ph      = SEQ_DARK;
        left_us = less_one(dly_tab[cur][3]);
      end
      SEQ_DARK: begin
        cur++;
        ph      = SEQ_ARM;
        left_us = '0;
        if (cur >= n_tasks) begin
          cur    = 0;
          run_on = run_next;
        end
        if (run_on) start_task();
      end
      default: start_task();
    endcase
  endfunction

  function void store_task(int unsigned slot, beat_in_t b);
    pin_tab[slot]  = b.pin;
    mask_tab[slot] = b.mask;
    dly_tab[slot]  = b.dly;
  endfunction

  function pin_state_t predict_pins(beat_in_t b);
    pin_state_t r;
    r       = '0;
    ev_flag = 1'b0;
    ev_pins = '0;
    if (b.op >= OP_ADD && b.op <= OP_REWRITE && run_on) begin
      r.status = STAT_BUSY;
    end else begin
      case (b.op)
        OP_TICK: begin
          r.ev_time = now_us;
          step_tick();
          now_us = now_us + 64'd1;
        end
        OP_ADD: begin
          if (n_tasks >= MAX_TASKS) r.status = STAT_FULL;
          else begin
            store_task(n_tasks, b);
            n_tasks++;
          end
        end
        OP_REMOVE: begin
          if (b.idx >= n_tasks) r.status = STAT_RANGE;
          else begin
            for (int i = int'(b.idx); i + 1 < n_tasks; i++) begin
              pin_tab[i]  = pin_tab[i+1];
              mask_tab[i] = mask_tab[i+1];
              dly_tab[i]  = dly_tab[i+1];
            end
            n_tasks--;
          end
        end
        OP_CLEAR: n_tasks = 0;
        OP_REWRITE: begin
          if (b.idx >= n_tasks) r.status = STAT_RANGE;
          else store_task(b.idx, b);
        end
        OP_ENABLE: begin
          run_next = b.en;
          if (!run_on) begin
            run_on  = run_next;
            cur     = 0;
            ph      = SEQ_ARM;
            left_us = '0;
            if (run_on) rounds_started++;
          end
        end
        default: ;
      endcase
    end
    if (run_on && n_tasks != 0 && ph >= SEQ_PRE_CAM && ph <= SEQ_POST_CAM) begin
      r.lasers = 32'd1 << pin_tab[cur];
      if (ph == SEQ_CAM) r.cams = mask_tab[cur];
    end
    r.ev = ev_flag;
    if (ev_flag) r.ev_state = ev_pins;
    else r.ev_time = '0;
    return r;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_beat(beat_in_t b);
    logic [S_TDATA_W-1:0] v;
    v = '0;
    v[169:0] = {b.en, b.dly[3], b.dly[2], b.dly[1], b.dly[0], b.mask, b.pin, b.idx};
    return v;
  endfunction

  function automatic beat_in_t mk_beat(logic [2:0] op, logic [3:0] idx, logic [4:0] pin,
                                       logic [31:0] mask, logic [31:0] d0, logic [31:0] d1,
                                       logic [31:0] d2, logic [31:0] d3, logic en);
    beat_in_t b;
    b.op = op; b.idx = idx; b.pin = pin; b.mask = mask;
    b.dly = {d3, d2, d1, d0};
    b.en = en;
    return b;
  endfunction

  function automatic beat_in_t rand_beat(logic [2:0] op, bit wide);
    beat_in_t b;
    int sel;
    b.op = op;
    if (n_tasks > 0 && $urandom_range(0, 3) != 0) b.idx = 4'($urandom_range(0, n_tasks - 1));
    else b.idx = 4'($urandom_range(0, 15));
    b.pin = 5'($urandom_range(0, 31));
    sel = $urandom_range(0, 7);
    b.mask = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hffff_ffff : $urandom;
    for (int k = 0; k < 4; k++) begin
      if (wide) b.dly[k] = $urandom;
      else if ($urandom_range(0, 7) == 0) b.dly[k] = $urandom_range(0, 7);
      else b.dly[k] = $urandom_range(0, 3);
    end
    b.en = 1'($urandom_range(0, 1));
    return b;
  endfunction

  task automatic push_beat(beat_in_t b, bit typed, status_t want_st);
    pin_state_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= pack_beat(b);
    s_tuser  <= b.op;
    do @(posedge clk); while (!s_tready);
    r = predict_pins(b);
    if (typed) begin
      r = '0;
      r.status = want_st;
    end
    results_due.push_back(r);
    beats_sent++;
    if (beats_sent > CALM_AFTER) calm = 1;
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_beat(beat_in_t b);
    push_beat(b, 1'b0, STAT_OK);
  endtask

  task automatic stop_sequencer();
    beat_in_t b;
    if (run_on) begin
      b = rand_beat(OP_ENABLE, 0);
      b.en = 1'b0;
      send_beat(b);
    end
    while (run_on) send_beat(rand_beat(OP_TICK, 0));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_session(int n);
    int k;
    int roll;
    beat_in_t b;
    stop_sequencer();
    if (n == 2) hold_req <= hold_req + 4'd1;
    if (n == 4) wait_drained();
    k = $urandom_range(4, 14);
    repeat (k) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) b = rand_beat(OP_ADD, $urandom_range(0, 5) == 0);
      else if (roll < 55) b = rand_beat(OP_REMOVE, 0);
      else if (roll < 75) b = rand_beat(OP_REWRITE, $urandom_range(0, 5) == 0);
      else if (roll < 80) b = rand_beat(OP_CLEAR, 0);
      else if (roll < 90) b = rand_beat(OP_TICK, 0);
      else if (roll < 95) b = rand_beat($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, 0);
      else begin
        b = rand_beat(OP_ENABLE, 0);
        b.en = 1'b0;
      end
      send_beat(b);
    end
    // keep rounds short: rewrite any task carrying long delays
    for (int i = 0; i < n_tasks; i++) begin
      if (dly_tab[i][0] > 7 || dly_tab[i][1] > 7 || dly_tab[i][2] > 7 || dly_tab[i][3] > 7)
      begin
        b = rand_beat(OP_REWRITE, 0);
        b.idx = 4'(i);
        send_beat(b);
      end
    end
    if (n_tasks == 0 && $urandom_range(0, 3) != 0) send_beat(rand_beat(OP_ADD, 0));
    b = rand_beat(OP_ENABLE, 0);
    b.en = 1'b1;
    send_beat(b);
    k = $urandom_range(10, 60);
    repeat (k) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) b = rand_beat(OP_TICK, 0);
      else if (roll < 88) b = rand_beat(3'($urandom_range(OP_ADD, OP_REWRITE)), 0);
      else if (roll < 95) b = rand_beat(OP_ENABLE, 0);
      else b = rand_beat($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, 0);
      send_beat(b);
    end
  endtask

  function void add_row(beat_in_t b, int reps, bit typed, status_t st);
    dir_row_t row;
    row.beat = b; row.reps = reps; row.typed = typed; row.want_st = st;
    dir_rows.push_back(row);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    pin_state_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing outstanding, actual %0h/%0h",
               $time, m_tuser, m_tdata);
    end else begin
      want = results_due.pop_front();
      results_seen++;
      if (m_tuser[2]) events_seen++;
      check_field("status", 64'(want.status), 64'(m_tuser[1:0]));
      check_field("event_valid", 64'(want.ev), 64'(m_tuser[2]));
      check_field("laser_pins", 64'(want.lasers), 64'(m_tdata[31:0]));
      check_field("camera_pins", 64'(want.cams), 64'(m_tdata[63:32]));
      check_field("event_state", 64'(want.ev_state), 64'(m_tdata[95:64]));
      check_field("event_time", want.ev_time, m_tdata[159:96]);
    end
  endtask

  // result side: checker plus random back-pressure
  int         stall_left = 0;
  int         hold_left = 0;
  logic [3:0] hold_served = '0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req != hold_served) begin
      hold_served = hold_req;
      hold_left   = HOLD_CYCLES - 1;
      m_tready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timed_exposure_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    int session;
    add_row(mk_beat(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_RANGE);
    add_row(mk_beat(OP_REWRITE, 15, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_RANGE);
    add_row(mk_beat(OP_SPARE6, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    // running with an empty table
    add_row(mk_beat(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 1), 1, 1, STAT_OK);
    add_row(mk_beat(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_BUSY);
    add_row(mk_beat(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    // fill the table, all-ones fields first
    add_row(mk_beat(OP_ADD, 15, 31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff_ffff, 1), 1, 1, STAT_OK);
    add_row(mk_beat(OP_REWRITE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_ADD, 7, 17, 32'h5a5a_a5a5, 1, 2, 3, 4, 0), 15, 1, STAT_OK);
    add_row(mk_beat(OP_ADD, 0, 9, 32'h1234_5678, 1, 1, 1, 1, 0), 1, 1, STAT_FULL);
    add_row(mk_beat(OP_REMOVE, 15, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    // short two-task round, disabled mid-round
    add_row(mk_beat(OP_ADD, 0, 3, 32'h0000_00f0, 0, 1, 2, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_ADD, 0, 31, 32'h8000_0001, 0, 0, 0, 0, 0), 1, 1, STAT_OK);
    add_row(mk_beat(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 1), 1, 0, STAT_OK);
    add_row(mk_beat(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 6, 0, STAT_OK);
    add_row(mk_beat(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, STAT_OK);
    add_row(mk_beat(OP_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, STAT_OK);
    add_row(mk_beat(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 12, 0, STAT_OK);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want_st);
    wait_drained();

    session = 0;
    while (beats_sent < BEAT_TARGET) begin
      run_session(session);
      session++;
    end
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d beats over %0d sessions, %0d results checked", beats_sent, session,
             results_seen);
    $display("%0d rounds started, %0d laser/camera events, %0d us simulated", rounds_started,
             events_seen, now_us);
    if (errors == 0) begin
      $display("timed_exposure_sequencer: match");
    end else begin
      $display("timed_exposure_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tes_pkg.sv
rtl/tes_datapath.sv
rtl/tes_ctrl.sv
rtl/timed_exposure_sequencer.sv
sim/timed_exposure_sequencer_tb.sv
